// ===== hw/rtl/vsam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsam_pkg
// Shared types and constants for the voice slot mixer: command and result
// records, opcode, status and sequencer state codes.
// ----------------------------------------------------------------------------
package vsam_pkg;

  localparam int VOICES_DEF      = 30;
  localparam int STORE_WORDS_DEF = 65536;
  localparam int SAMPLE_W        = 16;
  localparam int ADDR_W          = 16;
  localparam int LEN_W           = 17;
  localparam int ACTION_W        = 2;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 5;
  localparam int ADDR_BIT_W      = 4;
  localparam int CMD_Q_DEPTH     = 2;
  localparam int RES_Q_DEPTH     = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_QUEUE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_QUEUE,
    CMD_REJECT,
    CMD_TICK,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NO_SLOT  = 2'd1,
    STS_ZERO_LEN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_REDUCE,
    B_WRITE,
    B_SCAN,
    B_TICK,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic [ADDR_W-1:0]           addr;
    logic signed [SAMPLE_W-1:0]  value;
    logic [LEN_W-1:0]            len;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  mixed_sample;
    status_t                     status;
    logic [COUNT_W-1:0]          slot_taken;
    logic [COUNT_W-1:0]          active_count;
  } result_t;

endpackage

// ===== hw/rtl/voice_slot_audio_mixer_core.sv =====
`timescale 1ns / 1ps
// A queue request takes the lowest free slot; a tick walks the voice table one
// slot per cycle. Address reduction: reciprocal multiply, then one correction.
// The engine handles one transaction at a time, with two buffered on each side.
// Reset (rst_n low, synchronous) frees all slots, returns the engine to idle and
// empties both queues; the sample store and voice table are not cleared.
// ----------------------------------------------------------------------------
// voice_slot_audio_mixer_core
// Multi-voice saturating PCM mixer with a fixed table of voice slots.
// ----------------------------------------------------------------------------
module voice_slot_audio_mixer_core #(
  parameter int VOICES      = vsam_pkg::VOICES_DEF,
  parameter int STORE_WORDS = vsam_pkg::STORE_WORDS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [vsam_pkg::ACTION_W-1:0]         in_action,
  input  logic [vsam_pkg::ADDR_W-1:0]           in_address,
  input  logic signed [vsam_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [vsam_pkg::LEN_W-1:0]            in_sound_length,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [vsam_pkg::SAMPLE_W-1:0]  out_mixed_sample,
  output logic [vsam_pkg::STATUS_W-1:0]         out_status,
  output logic [vsam_pkg::COUNT_W-1:0]          out_slot_taken,
  output logic [vsam_pkg::COUNT_W-1:0]          out_active_count
);

  logic                                 cmd_valid;
  logic                                 cmd_pop;
  vsam_pkg::cmd_t                       cmd;
  logic                                 res_full;
  logic                                 res_push;
  vsam_pkg::result_t                    res;
  logic [$bits(vsam_pkg::result_t)-1:0] res_q_rdata;
  vsam_pkg::result_t                    res_head;

  vsam_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_address      (in_address),
    .in_sample_value (in_sample_value),
    .in_sound_length (in_sound_length),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop),
    .cmd             (cmd)
  );

  vsam_back #(
    .VOICES      (VOICES),
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  vsam_fifo #(
    .WIDTH ($bits(vsam_pkg::result_t)),
    .DEPTH (vsam_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q_rdata),
    .empty (out_empty)
  );

  assign res_head         = vsam_pkg::result_t'(res_q_rdata);
  assign out_mixed_sample = res_head.mixed_sample;
  assign out_status       = res_head.status;
  assign out_slot_taken   = res_head.slot_taken;
  assign out_active_count = res_head.active_count;

endmodule

// ===== hw/rtl/vsam_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsam_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module vsam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/vsam_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsam_fifo
// Small register-based queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module vsam_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/vsam_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsam_front
// Input side: decodes each incoming transaction into a command kind and
// queues it for the voice engine.
// ----------------------------------------------------------------------------
module vsam_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [vsam_pkg::ACTION_W-1:0]         in_action,
  input  logic [vsam_pkg::ADDR_W-1:0]           in_address,
  input  logic signed [vsam_pkg::SAMPLE_W-1:0]  in_sample_value,
  input  logic [vsam_pkg::LEN_W-1:0]            in_sound_length,
  output logic                                  cmd_valid,
  input  logic                                  cmd_pop,
  output vsam_pkg::cmd_t                        cmd
);

  vsam_pkg::cmd_t                    cmd_in;
  logic [$bits(vsam_pkg::cmd_t)-1:0] q_rdata;
  logic                              q_empty;

  // Zero-length queue requests are rejected here, before any slot search.
  always_comb begin
    cmd_in.addr  = in_address;
    cmd_in.value = in_sample_value;
    cmd_in.len   = in_sound_length;
    case (vsam_pkg::action_t'(in_action))
      vsam_pkg::ACT_WRITE: cmd_in.kind = vsam_pkg::CMD_WRITE;
      vsam_pkg::ACT_QUEUE: begin
        cmd_in.kind = (in_sound_length == '0) ? vsam_pkg::CMD_REJECT
                                              : vsam_pkg::CMD_QUEUE;
      end
      vsam_pkg::ACT_TICK:  cmd_in.kind = vsam_pkg::CMD_TICK;
      default:             cmd_in.kind = vsam_pkg::CMD_NOP;
    endcase
  end

  vsam_fifo #(
    .WIDTH ($bits(vsam_pkg::cmd_t)),
    .DEPTH (vsam_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = vsam_pkg::cmd_t'(q_rdata);

endmodule

// ===== hw/rtl/vsam_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsam_back
// Voice engine: reduces store addresses, stores samples, allocates slots and
// runs the per-tick mix as a three-stage pipeline over the voice table.
// ----------------------------------------------------------------------------
module vsam_back #(
  parameter int VOICES      = vsam_pkg::VOICES_DEF,
  parameter int STORE_WORDS = vsam_pkg::STORE_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  vsam_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output vsam_pkg::result_t   res
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int RW = AW + 1;
  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam int LW = vsam_pkg::LEN_W;
  localparam int VW = AW + LW;
  localparam int SW = vsam_pkg::SAMPLE_W;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / STORE_WORDS);

  vsam_pkg::back_state_t state_r, state_nxt;
  vsam_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [RW-1:0]         red_r, red_nxt;
  logic [vsam_pkg::ADDR_BIT_W-1:0] bit_r, bit_nxt;
  logic [vsam_pkg::ADDR_W-1:0]     quo_r, quo_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic                  s1_v_r, s1_v_nxt;
  logic [IW-1:0]         s1_k_r, s1_k_nxt;
  logic                  s2_v_r, s2_v_nxt;
  logic signed [SW-1:0]  acc_r, acc_nxt;
  logic                  busy_r [VOICES];
  logic                  busy_nxt [VOICES];
  logic [CW-1:0]         cnt_r, cnt_nxt;
  vsam_pkg::status_t     sts_r, sts_nxt;
  logic [IW-1:0]         slot_r, slot_nxt;

  logic          start;
  logic [47:0]   quo_prod;
  logic [31:0]   rem_prod;
  logic [31:0]   rem_raw;
  logic [31:0]   rem_fix;
  logic [IW-1:0] scan_idx;
  logic          scan_end;
  logic          scan_free;

  logic          vr_we;
  logic [IW-1:0] vr_waddr;
  logic [VW-1:0] vr_wdata;
  logic [VW-1:0] vr_rdata;
  logic [AW-1:0] v_cur;
  logic [LW-1:0] v_rem;
  logic [AW:0]   cur_inc;
  logic [AW-1:0] cur_nxt;
  logic          s1_hit;

  logic          sr_we;
  logic [SW-1:0] sr_rdata;
  logic [SW:0]   sum;
  logic signed [SW-1:0] sum_sat;

  assign start = (state_r == vsam_pkg::B_IDLE) && cmd_valid && !res_full;

  // Address mod store size: reciprocal quotient estimate (at most one low),
  // then subtract and correct once.
  assign quo_prod = 48'(cmd_r.addr) * 48'(RECIP);
  assign rem_prod = 32'(quo_r) * 32'(STORE_WORDS);
  assign rem_raw  = 32'(cmd_r.addr) - rem_prod;
  assign rem_fix  = (rem_raw >= 32'(STORE_WORDS)) ? rem_raw - 32'(STORE_WORDS) : rem_raw;

  assign scan_idx  = scan_r[IW-1:0];
  assign scan_end  = (scan_r == CW'(VOICES));
  assign scan_free = !scan_end && !busy_r[scan_idx];

  assign v_cur   = vr_rdata[VW-1:LW];
  assign v_rem   = vr_rdata[LW-1:0];
  assign cur_inc = {1'b0, v_cur} + 1'b1;
  assign cur_nxt = (cur_inc == (AW + 1)'(STORE_WORDS)) ? '0 : cur_inc[AW-1:0];
  assign s1_hit  = s1_v_r && busy_r[s1_k_r];

  assign sum     = {acc_r[SW-1], acc_r} + {sr_rdata[SW-1], sr_rdata};
  assign sum_sat = (sum[SW] != sum[SW-1]) ?
                   (sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
                   : sum[SW-1:0];

  assign sr_we = (state_r == vsam_pkg::B_WRITE);

  vsam_ram #(
    .WIDTH (VW),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (vr_we),
    .waddr (vr_waddr),
    .wdata (vr_wdata),
    .raddr (scan_idx),
    .rdata (vr_rdata)
  );

  vsam_ram #(
    .WIDTH (SW),
    .DEPTH (STORE_WORDS)
  ) u_sample_ram (
    .clk   (clk),
    .we    (sr_we),
    .waddr (red_r[AW-1:0]),
    .wdata (cmd_r.value),
    .raddr (v_cur),
    .rdata (sr_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vsam_pkg::B_IDLE: begin
        if (start) begin
          case (cmd.kind)
            vsam_pkg::CMD_WRITE,
            vsam_pkg::CMD_QUEUE: state_nxt = vsam_pkg::B_REDUCE;
            vsam_pkg::CMD_TICK:  state_nxt = vsam_pkg::B_TICK;
            default:             state_nxt = vsam_pkg::B_EMIT;
          endcase
        end
      end
      vsam_pkg::B_REDUCE: begin
        if (bit_r == '0) begin
          state_nxt = (cmd_r.kind == vsam_pkg::CMD_WRITE) ? vsam_pkg::B_WRITE
                                                         : vsam_pkg::B_SCAN;
        end
      end
      vsam_pkg::B_WRITE: state_nxt = vsam_pkg::B_EMIT;
      vsam_pkg::B_SCAN: begin
        if (scan_end || scan_free) begin
          state_nxt = vsam_pkg::B_EMIT;
        end
      end
      vsam_pkg::B_TICK: begin
        if (scan_end && !s1_v_r && !s2_v_r) begin
          state_nxt = vsam_pkg::B_EMIT;
        end
      end
      vsam_pkg::B_EMIT: state_nxt = vsam_pkg::B_IDLE;
      default:          state_nxt = vsam_pkg::B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_pop  = start;
    res_push = (state_r == vsam_pkg::B_EMIT);
    res.mixed_sample = acc_r;
    res.status       = sts_r;
    res.slot_taken   = vsam_pkg::COUNT_W'(slot_r);
    res.active_count = vsam_pkg::COUNT_W'(cnt_r);
  end

  // Datapath
  always_comb begin
    cmd_nxt  = cmd_r;
    red_nxt  = red_r;
    bit_nxt  = bit_r;
    quo_nxt  = quo_r;
    scan_nxt = scan_r;
    s1_v_nxt = 1'b0;
    s1_k_nxt = s1_k_r;
    s2_v_nxt = 1'b0;
    acc_nxt  = acc_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sts_nxt  = sts_r;
    slot_nxt = slot_r;
    vr_we    = 1'b0;
    vr_waddr = s1_k_r;
    vr_wdata = {cur_nxt, v_rem - 1'b1};
    case (state_r)
      vsam_pkg::B_IDLE: begin
        if (start) begin
          cmd_nxt  = cmd;
          red_nxt  = '0;
          bit_nxt  = vsam_pkg::ADDR_BIT_W'(1);
          scan_nxt = '0;
          acc_nxt  = '0;
          slot_nxt = '0;
          sts_nxt  = (cmd.kind == vsam_pkg::CMD_REJECT) ? vsam_pkg::STS_ZERO_LEN
                                                         : vsam_pkg::STS_OK;
        end
      end
      vsam_pkg::B_REDUCE: begin
        if (bit_r != '0) begin
          quo_nxt = quo_prod[47:32];
        end else begin
          red_nxt = RW'(rem_fix);
        end
        bit_nxt = bit_r - 1'b1;
      end
      vsam_pkg::B_SCAN: begin
        if (scan_free) begin
          busy_nxt[scan_idx] = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          slot_nxt = scan_idx;
          vr_we    = 1'b1;
          vr_waddr = scan_idx;
          vr_wdata = {red_r[AW-1:0], cmd_r.len};
        end else if (scan_end) begin
          sts_nxt = vsam_pkg::STS_NO_SLOT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      vsam_pkg::B_TICK: begin
        // Stage 0: read the voice entry.
        if (!scan_end) begin
          s1_v_nxt = 1'b1;
          s1_k_nxt = scan_idx;
          scan_nxt = scan_r + 1'b1;
        end
        // Stage 1: fetch its sample, advance, free after the last sample.
        if (s1_hit) begin
          vr_we    = 1'b1;
          s2_v_nxt = 1'b1;
          if (v_rem == LW'(1)) begin
            busy_nxt[s1_k_r] = 1'b0;
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        // Stage 2: accumulate with saturation.
        if (s2_v_r) begin
          acc_nxt = sum_sat;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vsam_pkg::B_IDLE;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      cnt_r   <= '0;
      for (int i = 0; i < VOICES; i++) begin
        busy_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    red_r  <= red_nxt;
    bit_r  <= bit_nxt;
    quo_r  <= quo_nxt;
    scan_r <= scan_nxt;
    s1_k_r <= s1_k_nxt;
    acc_r  <= acc_nxt;
    sts_r  <= sts_nxt;
    slot_r <= slot_nxt;
  end

endmodule

// ===== hw/rtl/vsam_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsam_checker
// Port-level checks for the voice slot mixer, bound to the top level.
// ----------------------------------------------------------------------------
module vsam_checker #(
  parameter int VOICES = vsam_pkg::VOICES_DEF
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_full,
  input logic                                  out_empty,
  input logic                                  out_pop,
  input logic signed [vsam_pkg::SAMPLE_W-1:0]  out_mixed_sample,
  input logic [vsam_pkg::STATUS_W-1:0]         out_status,
  input logic [vsam_pkg::COUNT_W-1:0]          out_slot_taken,
  input logic [vsam_pkg::COUNT_W-1:0]          out_active_count
);

  // A failed slot search means every slot is occupied.
  a_no_slot_full: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_status == vsam_pkg::STS_NO_SLOT |->
      out_active_count == vsam_pkg::COUNT_W'(VOICES) &&
      out_slot_taken == '0 && out_mixed_sample == '0)
    else $error("no-slot result with free slots or stray fields");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_status == vsam_pkg::STS_ZERO_LEN |->
      out_slot_taken == '0 && out_mixed_sample == '0)
    else $error("zero-length reject carries a slot or sample");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("pending result dropped without pop");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

endmodule

bind voice_slot_audio_mixer_core vsam_checker #(
  .VOICES (VOICES)
) u_vsam_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_mixed_sample (out_mixed_sample),
  .out_status       (out_status),
  .out_slot_taken   (out_slot_taken),
  .out_active_count (out_active_count)
);

// ===== bench/tb_voice_slot_audio_mixer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voice_slot_audio_mixer_core
// Self-checking bench for the voice slot mixer. A short directed sequence hits
// zero-length, wrapping and oversized sounds, clipping and unused actions;
// random traffic then mixes sample writes, queue bursts that exhaust the slot
// table, and ticks. A scoreboard class keeps its own voice table and sample
// store, predicts every result and compares each popped result field by field.
// ----------------------------------------------------------------------------
module tb_voice_slot_audio_mixer_core;
  import vsam_pkg::*;

  localparam int VOICE_SLOTS  = VOICES_DEF;
  localparam int ITEMS        = 1350;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int BURST_EVERY  = 400;

  typedef struct {
    action_t                    act;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] value;
    logic [LEN_W-1:0]           len;
  } mix_cmd_t;

  class mix_scoreboard;
    bit                         busy [VOICE_SLOTS];
    logic [ADDR_W-1:0]          start_addr [VOICE_SLOTS];
    logic [LEN_W-1:0]           length [VOICE_SLOTS];
    logic [LEN_W-1:0]           position [VOICE_SLOTS];
    logic signed [SAMPLE_W-1:0] store [STORE_WORDS_DEF];
    bit                         written [STORE_WORDS_DEF];
    result_t                    expected_q [$];
    int errors, n_in, n_out, n_ticks, n_no_slot, n_zero_len, n_clipped;

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted transaction to the voice table and queue its result.
    function void note_cmd(mix_cmd_t c);
      result_t           r;
      int                sum;
      int                found;
      int                active;
      logic [ADDR_W-1:0] a;
      r = '0;
      found = -1;
      active = 0;
      n_in++;
      case (c.act)
        ACT_WRITE: begin
          store[c.addr] = c.value;
          written[c.addr] = 1'b1;
        end
        ACT_QUEUE: begin
          if (c.len == '0) begin
            r.status = STS_ZERO_LEN;
            n_zero_len++;
          end else begin
            for (int k = 0; k < VOICE_SLOTS; k++) begin
              if (!busy[k]) begin
                found = k;
                break;
              end
            end
            if (found < 0) begin
              r.status = STS_NO_SLOT;
              n_no_slot++;
            end else begin
              busy[found] = 1'b1;
              start_addr[found] = c.addr;
              length[found] = c.len;
              position[found] = '0;
              r.slot_taken = found[COUNT_W-1:0];
            end
          end
        end
        ACT_TICK: begin
          n_ticks++;
          sum = 0;
          for (int k = 0; k < VOICE_SLOTS; k++) begin
            if (busy[k]) begin
              if (position[k] < length[k]) begin
                a = start_addr[k] + position[k][ADDR_W-1:0];
                sum += int'(store[a]);
                // clip after every addition, not once at the end
                if (sum > 32767) begin
                  sum = 32767;
                  n_clipped++;
                end
                if (sum < -32768) begin
                  sum = -32768;
                  n_clipped++;
                end
                position[k]++;
              end
              if (position[k] >= length[k]) begin
                busy[k] = 1'b0;
                start_addr[k] = '0;
                length[k] = '0;
                position[k] = '0;
              end
            end
          end
          r.mixed_sample = sum[SAMPLE_W-1:0];
        end
        default: ;
      endcase
      for (int k = 0; k < VOICE_SLOTS; k++)
        if (busy[k]) active++;
      r.active_count = active[COUNT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void compare_field(string field, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: mixed_sample %0d status %0d",
               got.mixed_sample, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      n_out++;
      compare_field("mixed_sample", 32'(want.mixed_sample), 32'(got.mixed_sample));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("slot_taken", 32'(want.slot_taken), 32'(got.slot_taken));
      compare_field("active_count", 32'(want.active_count), 32'(got.active_count));
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_push;
  logic                       in_full;
  logic [ACTION_W-1:0]        in_action;
  logic [ADDR_W-1:0]          in_address;
  logic signed [SAMPLE_W-1:0] in_sample_value;
  logic [LEN_W-1:0]           in_sound_length;
  logic                       out_empty;
  logic                       out_pop;
  logic signed [SAMPLE_W-1:0] out_mixed_sample;
  logic [STATUS_W-1:0]        out_status;
  logic [COUNT_W-1:0]         out_slot_taken;
  logic [COUNT_W-1:0]         out_active_count;

  mix_scoreboard sb;
  bit            sender_calm;
  bit            receiver_calm;
  int            n_sent;

  voice_slot_audio_mixer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_address      (in_address),
    .in_sample_value (in_sample_value),
    .in_sound_length (in_sound_length),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_mixed_sample(out_mixed_sample),
    .out_status      (out_status),
    .out_slot_taken  (out_slot_taken),
    .out_active_count(out_active_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Unused fields carry random bits so every input bit toggles.
  function automatic mix_cmd_t rand_cmd(action_t act);
    mix_cmd_t c;
    c.act = act;
    c.addr = ADDR_W'($urandom);
    c.value = SAMPLE_W'($urandom);
    c.len = LEN_W'($urandom);
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1:    return 16'sh7FFF;
      2:       return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Keep most sounds in a small window around zero so the store fills up.
  function automatic logic [ADDR_W-1:0] pool_addr();
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 9) == 0) a = ADDR_W'($urandom);
    else a = ADDR_W'($urandom_range(0, 1023) - 512);
    return a;
  endfunction

  function automatic logic [LEN_W-1:0] short_len();
    if ($urandom_range(0, 7) == 0) return LEN_W'($urandom_range(13, 64));
    return LEN_W'($urandom_range(1, 12));
  endfunction

  task automatic send_cmd(input mix_cmd_t c);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_action       <= c.act;
    in_address      <= c.addr;
    in_sample_value <= c.value;
    in_sound_length <= c.len;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_cmd(c);
    n_sent++;
    if (n_sent % 50 == 0) sender_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_write(input logic [ADDR_W-1:0] addr,
                            input logic signed [SAMPLE_W-1:0] value);
    mix_cmd_t c;
    c = rand_cmd(ACT_WRITE);
    c.addr = addr;
    c.value = value;
    send_cmd(c);
  endtask

  task automatic send_queue(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
    mix_cmd_t c;
    c = rand_cmd(ACT_QUEUE);
    c.addr = addr;
    c.len = len;
    send_cmd(c);
  endtask

  // Write any store word the next tick will read that still holds no data.
  task automatic send_tick();
    logic [ADDR_W-1:0] a;
    for (int k = 0; k < VOICE_SLOTS; k++) begin
      if (sb.busy[k]) begin
        a = sb.start_addr[k] + sb.position[k][ADDR_W-1:0];
        if (!sb.written[a]) send_write(a, rand_sample());
      end
    end
    send_cmd(rand_cmd(ACT_TICK));
  endtask

  initial begin : stimulus
    mix_cmd_t c;
    int       pick;
    int       next_burst;
    bit       paused;
    sb = new();
    next_burst = 0;
    paused = 1'b0;
    rst_n           <= 1'b0;
    in_push         <= 1'b0;
    in_action       <= ACT_NONE;
    in_address      <= '0;
    in_sample_value <= '0;
    in_sound_length <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    c = rand_cmd(ACT_NONE);
    c.addr = '1;
    c.value = '1;
    c.len = '1;
    send_cmd(c);
    send_write(16'h0000, 16'sh7FFF);
    send_write(16'h0001, 16'sh7FFF);
    send_write(16'hFFFF, 16'sh8000);
    send_queue(16'h0005, '0);
    send_queue(16'h0000, 17'd2);
    send_queue(16'h0000, 17'd2);
    // third voice starts at the top of the store and wraps to zero
    send_queue(16'hFFFF, 17'd3);
    send_tick();
    send_tick();
    send_tick();
    send_queue(16'h8000, 17'd65536);
    send_queue(16'h4000, 17'h1FFFF);
    send_tick();
    send_tick();
    send_cmd(rand_cmd(ACT_NONE));

    while (n_sent < ITEMS) begin
      // exhaust the slot table now and then
      if (n_sent >= next_burst) begin
        repeat (VOICE_SLOTS + 4) send_queue(pool_addr(), short_len());
        next_burst += BURST_EVERY;
      end
      if (!paused && n_sent >= ITEMS / 2) begin
        paused = 1'b1;
        in_push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) send_write(pool_addr(), rand_sample());
      else if (pick < 14) send_cmd(rand_cmd(ACT_NONE));
      else if (pick < 18) send_queue(ADDR_W'($urandom), '0);
      else if (pick < 46) send_queue(pool_addr(), short_len());
      else send_tick();
    end

    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d transactions, %0d results checked, %0d ticks, %0d clip events.",
             sb.n_in, sb.n_out, sb.n_ticks, sb.n_clipped);
    $display("Queue rejects: %0d with no free slot, %0d with zero length.",
             sb.n_no_slot, sb.n_zero_len);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin : drain_results
    result_t got;
    int      gap;
    int      popped;
    popped = 0;
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = receiver_calm ? 0 : $urandom_range(0, 19);
      // hold off long enough for both queues to fill and stall the sender
      if (popped == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      got.mixed_sample = out_mixed_sample;
      got.status = status_t'(out_status);
      got.slot_taken = out_slot_taken;
      got.active_count = out_active_count;
      sb.check_result(got);
      popped++;
      if (popped % 50 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
    end
  end

endmodule
